@@ design/mbd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbd_pkg
// Types and constants shared by the banked memory bus decoder.
// ----------------------------------------------------------------------------
package mbd_pkg;

    localparam int ROM_ADDRESS_BITS = 19;
    localparam int STORE_DEPTH      = 65536;
    localparam int STORE_AW         = $clog2(STORE_DEPTH);
    localparam int ROM_FIELD_W      = 19;
    localparam int BANK_W           = 5;
    localparam int WINDOW_W         = 14;

    localparam logic [ROM_FIELD_W-1:0] ROM_MASK =
        ROM_FIELD_W'((64'd1 << ROM_ADDRESS_BITS) - 64'd1);

    localparam logic [15:0] ADDR_WINDOW  = 16'h4000;
    localparam logic [15:0] ADDR_VIDEO   = 16'h8000;
    localparam logic [15:0] ADDR_RAMEN   = 16'h2000;
    localparam logic [15:0] ADDR_VID_END = 16'hA000;
    localparam logic [15:0] ADDR_OAM     = 16'hFE00;
    localparam logic [15:0] ADDR_OAM_END = 16'hFE9F;
    localparam logic [15:0] ADDR_TMR     = 16'hFF03;
    localparam logic [15:0] ADDR_TMR_END = 16'hFF07;
    localparam logic [15:0] ADDR_LCD     = 16'hFF40;
    localparam logic [15:0] ADDR_LCD_END = 16'hFF4B;
    localparam logic [15:0] ADDR_JOYPAD  = 16'hFF00;
    localparam logic [15:0] ADDR_IFLAG   = 16'hFF0F;

    localparam logic [7:0] JOYPAD_IDLE = 8'hCF;
    localparam logic [7:0] IRQ_TIMER   = 8'h04;
    localparam logic [7:0] IRQ_VBLANK  = 8'h01;
    localparam logic [3:0] RAMEN_KEY   = 4'hA;

    typedef enum logic [1:0] {
        OP_READ   = 2'd0,
        OP_WRITE  = 2'd1,
        OP_TIMER  = 2'd2,
        OP_VBLANK = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ROUTE_HERE    = 3'd0,
        ROUTE_ROM     = 3'd1,
        ROUTE_VIDEO   = 3'd2,
        ROUTE_TIMER   = 3'd3,
        ROUTE_CONTROL = 3'd4
    } t_route;

    typedef enum logic [1:0] {
        ST_CLEAR = 2'd0,
        ST_IDLE  = 2'd1,
        ST_EXEC  = 2'd2
    } t_state;

    typedef struct packed {
        t_op         operation;
        logic [15:0] bus_address;
        logic [7:0]  write_data;
        logic [7:0]  joypad_lines;
    } t_bus_req;

    typedef struct packed {
        t_route                 route;
        logic [ROM_FIELD_W-1:0] rom_address;
        logic [7:0]             read_data;
    } t_bus_rsp;

endpackage

@@ design/banked_memory_bus_decoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// banked_memory_bus_decoder
// Address decoder of a CPU bus with a banked ROM window, joypad port and a
// 64K byte store whose interrupt flag byte is set by read-modify-write.
// ----------------------------------------------------------------------------
//  channel   signals                          direction
//  request   i_req_valid / o_req_ready / i_req   in
//  response  o_rsp_valid / i_rsp_ready / o_rsp   out
//
//  Each request is accepted in ST_IDLE, which issues the store read; ST_EXEC
//  then decodes, writes back and loads the response register.
//  After reset the store is cleared one byte a cycle, with o_req_ready low
//  until all 65536 bytes are cleared. A held response stalls the decode
//  step only; a new request is taken while a response waits.
// ----------------------------------------------------------------------------
module banked_memory_bus_decoder (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_valid,
    output logic             o_req_ready,
    input  mbd_pkg::t_bus_req i_req,
    output logic             o_rsp_valid,
    input  logic             i_rsp_ready,
    output mbd_pkg::t_bus_rsp o_rsp
);

    import mbd_pkg::*;

    t_state                r_state, n_state;
    logic [STORE_AW-1:0]   r_clr, n_clr;
    t_bus_req              r_req, n_req;
    logic [BANK_W-1:0]     r_bank, n_bank;
    logic                  r_ram_en, n_ram_en;
    logic [7:0]            r_joy_sel, n_joy_sel;
    logic                  r_out_valid, n_out_valid;
    t_bus_rsp              r_out, n_out;

    logic                  ram_we;
    logic [STORE_AW-1:0]   ram_waddr;
    logic [7:0]            ram_wdata;
    logic                  ram_re;
    logic [STORE_AW-1:0]   ram_raddr;
    logic [7:0]            ram_rdata;

    t_bus_rsp              dec_rsp;
    logic                  dec_st_we;
    logic [15:0]           dec_st_addr;
    logic [7:0]            dec_st_wdata;
    logic                  dec_bank_we;
    logic                  dec_ramen_we;
    logic                  dec_joy_we;
    t_route                dec_unit;
    logic [7:0]            dec_joy;
    logic [BANK_W-1:0]     dec_bank;

    mbd_ram #(
        .WIDTH (8),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    function automatic t_route unit_route(input logic [15:0] a);
        t_route r;
        r = ROUTE_HERE;
        if (a >= ADDR_VIDEO && a < ADDR_VID_END) begin
            r = ROUTE_VIDEO;
        end else if (a >= ADDR_OAM && a <= ADDR_OAM_END) begin
            r = ROUTE_VIDEO;
        end else if (a >= ADDR_TMR && a <= ADDR_TMR_END) begin
            r = ROUTE_TIMER;
        end else if (a >= ADDR_LCD && a <= ADDR_LCD_END) begin
            r = ROUTE_VIDEO;
        end
        return r;
    endfunction

    // decode of the held request against the store byte
    always_comb begin
        dec_rsp      = '0;
        dec_st_we    = 1'b0;
        dec_st_addr  = r_req.bus_address;
        dec_st_wdata = r_req.write_data;
        dec_bank_we  = 1'b0;
        dec_ramen_we = 1'b0;
        dec_joy_we   = 1'b0;
        dec_unit     = unit_route(r_req.bus_address);

        dec_joy = JOYPAD_IDLE;
        if (!r_joy_sel[4]) begin
            dec_joy[3:0] = r_req.joypad_lines[7:4];
        end
        if (!r_joy_sel[5]) begin
            dec_joy[3:0] = r_req.joypad_lines[3:0];
        end

        dec_bank = (r_req.write_data[BANK_W-1:0] == '0) ? BANK_W'(1)
                                                        : r_req.write_data[BANK_W-1:0];

        case (r_req.operation)
            OP_READ: begin
                if (r_req.bus_address < ADDR_WINDOW) begin
                    dec_rsp.route       = ROUTE_ROM;
                    dec_rsp.rom_address = ROM_FIELD_W'(r_req.bus_address) & ROM_MASK;
                end else if (r_req.bus_address < ADDR_VIDEO) begin
                    dec_rsp.route       = ROUTE_ROM;
                    dec_rsp.rom_address = {r_bank, r_req.bus_address[WINDOW_W-1:0]}
                                          & ROM_MASK;
                end else if (dec_unit != ROUTE_HERE) begin
                    dec_rsp.route = dec_unit;
                end else if (r_req.bus_address == ADDR_JOYPAD) begin
                    dec_rsp.read_data = dec_joy;
                end else begin
                    dec_rsp.read_data = ram_rdata;
                end
            end
            OP_WRITE: begin
                if (r_req.bus_address < ADDR_VIDEO) begin
                    dec_rsp.route = ROUTE_CONTROL;
                    if (r_req.bus_address < ADDR_RAMEN) begin
                        dec_ramen_we = 1'b1;
                    end else if (r_req.bus_address < ADDR_WINDOW) begin
                        dec_bank_we = 1'b1;
                    end
                end else if (dec_unit != ROUTE_HERE) begin
                    dec_rsp.route = dec_unit;
                end else if (r_req.bus_address == ADDR_JOYPAD) begin
                    dec_rsp.route = ROUTE_CONTROL;
                    dec_joy_we    = 1'b1;
                end else begin
                    dec_st_we = 1'b1;
                end
            end
            OP_TIMER: begin
                dec_st_we    = 1'b1;
                dec_st_addr  = ADDR_IFLAG;
                dec_st_wdata = ram_rdata | IRQ_TIMER;
            end
            default: begin
                dec_st_we    = 1'b1;
                dec_st_addr  = ADDR_IFLAG;
                dec_st_wdata = ram_rdata | IRQ_VBLANK;
            end
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_req       = r_req;
        n_bank      = r_bank;
        n_ram_en    = r_ram_en;
        n_joy_sel   = r_joy_sel;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_rsp_ready;
        o_req_ready = 1'b0;
        ram_we      = 1'b0;
        ram_waddr   = r_clr;
        ram_wdata   = '0;
        ram_re      = 1'b0;
        ram_raddr   = i_req.bus_address[STORE_AW-1:0];

        case (r_state)
            ST_CLEAR: begin
                ram_we = 1'b1;
                n_clr  = r_clr + STORE_AW'(1);
                if (r_clr == '1) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    ram_re = 1'b1;
                    if (i_req.operation == OP_TIMER || i_req.operation == OP_VBLANK) begin
                        ram_raddr = ADDR_IFLAG[STORE_AW-1:0];
                    end
                    n_req   = i_req;
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (!r_out_valid || i_rsp_ready) begin
                    n_out       = dec_rsp;
                    n_out_valid = 1'b1;
                    ram_we      = dec_st_we;
                    ram_waddr   = dec_st_addr[STORE_AW-1:0];
                    ram_wdata   = dec_st_wdata;
                    if (dec_bank_we) begin
                        n_bank = dec_bank;
                    end
                    if (dec_ramen_we) begin
                        n_ram_en = (r_req.write_data[3:0] == RAMEN_KEY);
                    end
                    if (dec_joy_we) begin
                        n_joy_sel = r_req.write_data;
                    end
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_bank      <= BANK_W'(1);
            r_ram_en    <= 1'b0;
            r_joy_sel   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_bank      <= n_bank;
            r_ram_en    <= n_ram_en;
            r_joy_sel   <= n_joy_sel;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req <= n_req;
        r_out <= n_out;
    end

    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_out;

endmodule

@@ design/mbd_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbd_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module mbd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
